FILE: design/u8d_pkg.sv
// u8d_pkg: shared types and constants of the UTF-8 stream decoder.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package u8d_pkg;

  // Item kinds on the byte channel
  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LEAD   = 3'd1,
    ST_OUT_OF_SEQ = 3'd2,
    ST_BAD_CODE   = 3'd3,
    ST_INCOMPLETE = 3'd4
  } status_t;

  typedef logic [1:0]  pend_t;   // continuation bytes still due
  typedef logic [20:0] code_t;   // code point accumulator

  // Byte class boundaries
  localparam logic [7:0] CONT_MIN     = 8'h80;
  localparam logic [7:0] LEAD2_MIN    = 8'hC0;
  localparam logic [7:0] LEAD3_MIN    = 8'hE0;
  localparam logic [7:0] LEAD4_MIN    = 8'hF0;
  localparam logic [7:0] BAD_LEAD_MIN = 8'hF8;

  // Code point limits
  localparam code_t CODE_MAX    = 21'h10FFFF;
  localparam code_t SURR_LO     = 21'h00D800;
  localparam code_t SURR_HI     = 21'h00DFFF;
  localparam code_t PLANE1_BASE = 21'h010000;

  // Continuation counts loaded by each lead class
  localparam pend_t PEND_LEAD2 = 2'd1;
  localparam pend_t PEND_LEAD3 = 2'd2;
  localparam pend_t PEND_LEAD4 = 2'd3;

  // One result item
  typedef struct packed {
    logic        has_char;
    logic [15:0] unit_low;
    logic [9:0]  unit_high;
    status_t     status;
  } out_item_t;

endpackage

`default_nettype wire

FILE: design/u8d_byte_if.sv
// u8d_byte_if: valid/ready channel carrying one input byte or end-of-stream item.
// Depends on u8d_pkg.
`default_nettype none

interface u8d_byte_if;
  logic           valid;
  logic           ready;
  u8d_pkg::kind_t kind;
  logic [7:0]     byte_value;

  modport source (output valid, kind, byte_value, input ready);
  modport sink   (input valid, kind, byte_value, output ready);
endinterface

`default_nettype wire

FILE: design/u8d_unit_if.sv
// u8d_unit_if: valid/ready channel carrying one decoded result item.
// Depends on u8d_pkg.
`default_nettype none

interface u8d_unit_if;
  logic             valid;
  logic             ready;
  logic             has_char;
  logic [15:0]      unit_low;
  logic [9:0]       unit_high;
  u8d_pkg::status_t status;

  modport source (output valid, has_char, unit_low, unit_high, status, input ready);
  modport sink   (input valid, has_char, unit_low, unit_high, status, output ready);
endinterface

`default_nettype wire

FILE: design/utf8_stream_decoder_core.sv
// utf8_stream_decoder_core: UTF-8 byte stream to 16-bit / split code units.
// Depends on u8d_pkg, u8d_byte_if and u8d_unit_if.
//
//   channel  | dir | payload                                 | items
//   ---------+-----+-----------------------------------------+------------------------
//   bytes    | in  | kind, byte_value                        | one byte or end mark
//   units    | out | has_char, unit_low, unit_high, status   | zero or one per input
//
// One item per cycle sustained while the result register is not stalled. An item
// waits in the input register, then the decode logic updates the pending count and
// accumulator and loads the result register when the item gives a result.
// Reset (rst, synchronous) clears the pending count, accumulator and valids.
// A stalled result register holds the input register; items that give no result
// still pass through when the output is stalled only if the result slot is free.
`default_nettype none

module utf8_stream_decoder_core (
  input  wire logic   clk,
  input  wire logic   rst,
  u8d_byte_if.sink    bytes,
  u8d_unit_if.source  units
);

  // Input register
  logic           s1_valid;
  u8d_pkg::kind_t s1_kind;
  logic [7:0]     s1_byte;

  // Decoder state
  u8d_pkg::pend_t pending;
  u8d_pkg::code_t accum;

  // Result register
  logic                 out_valid;
  u8d_pkg::out_item_t   out_item;

  // Decode results
  logic                 res_valid;
  u8d_pkg::out_item_t   res;
  u8d_pkg::pend_t       pending_next;
  u8d_pkg::code_t       accum_next;
  u8d_pkg::code_t       acc_shift;

  logic s1_consume;

  // Error result: no character, only a status
  function automatic u8d_pkg::out_item_t make_err(input u8d_pkg::status_t st);
    u8d_pkg::out_item_t r;
    r.has_char  = 1'b0;
    r.unit_low  = 16'd0;
    r.unit_high = 10'd0;
    r.status    = st;
    return r;
  endfunction

  // Range check and split of a finished code point
  function automatic u8d_pkg::out_item_t make_char(input u8d_pkg::code_t cp);
    u8d_pkg::out_item_t r;
    u8d_pkg::code_t     off;
    off = cp - u8d_pkg::PLANE1_BASE;
    if (cp > u8d_pkg::CODE_MAX ||
        (cp >= u8d_pkg::SURR_LO && cp <= u8d_pkg::SURR_HI)) begin
      r = make_err(u8d_pkg::ST_BAD_CODE);
    end else if (cp < u8d_pkg::PLANE1_BASE) begin
      r.has_char  = 1'b1;
      r.unit_low  = cp[15:0];
      r.unit_high = 10'd0;
      r.status    = u8d_pkg::ST_OK;
    end else begin
      r.has_char  = 1'b1;
      r.unit_low  = {6'd0, off[9:0]};
      r.unit_high = off[19:10];
      r.status    = u8d_pkg::ST_OK;
    end
    return r;
  endfunction

  // Handshakes: input register moves whenever the result slot can take a result
  assign s1_consume  = s1_valid && (!out_valid || units.ready);
  assign bytes.ready = !s1_valid || s1_consume;

  assign acc_shift = {accum[14:0], s1_byte[5:0]};

  // Decode one item against the current state
  always_comb begin
    res_valid    = 1'b0;
    res          = make_err(u8d_pkg::ST_OK);
    pending_next = pending;
    accum_next   = accum;
    if (s1_kind == u8d_pkg::KIND_END) begin
      // end of stream always clears; an open character is reported
      pending_next = 2'd0;
      accum_next   = '0;
      if (pending != 2'd0) begin
        res_valid = 1'b1;
        res       = make_err(u8d_pkg::ST_INCOMPLETE);
      end
    end else if (s1_byte < u8d_pkg::CONT_MIN) begin
      res_valid = 1'b1;
      if (pending != 2'd0) begin
        res          = make_err(u8d_pkg::ST_OUT_OF_SEQ);
        pending_next = 2'd0;
        accum_next   = '0;
      end else begin
        res = make_char({13'd0, s1_byte});
      end
    end else if (s1_byte >= u8d_pkg::BAD_LEAD_MIN) begin
      res_valid    = 1'b1;
      res          = make_err(u8d_pkg::ST_BAD_LEAD);
      pending_next = 2'd0;
      accum_next   = '0;
    end else if (s1_byte >= u8d_pkg::LEAD2_MIN) begin
      // lead byte: load count and payload bits
      if (pending != 2'd0) begin
        res_valid    = 1'b1;
        res          = make_err(u8d_pkg::ST_OUT_OF_SEQ);
        pending_next = 2'd0;
        accum_next   = '0;
      end else if (s1_byte >= u8d_pkg::LEAD4_MIN) begin
        pending_next = u8d_pkg::PEND_LEAD4;
        accum_next   = {18'd0, s1_byte[2:0]};
      end else if (s1_byte >= u8d_pkg::LEAD3_MIN) begin
        pending_next = u8d_pkg::PEND_LEAD3;
        accum_next   = {17'd0, s1_byte[3:0]};
      end else begin
        pending_next = u8d_pkg::PEND_LEAD2;
        accum_next   = {16'd0, s1_byte[4:0]};
      end
    end else begin
      // continuation byte
      if (pending == 2'd0) begin
        res_valid = 1'b1;
        res       = make_err(u8d_pkg::ST_OUT_OF_SEQ);
        accum_next = '0;
      end else if (pending == 2'd1) begin
        res_valid    = 1'b1;
        res          = make_char(acc_shift);
        pending_next = 2'd0;
        accum_next   = '0;
      end else begin
        pending_next = pending - 2'd1;
        accum_next   = acc_shift;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
    if (bytes.valid && bytes.ready) begin
      s1_kind <= bytes.kind;
      s1_byte <= bytes.byte_value;
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      accum   <= '0;
    end else if (s1_consume) begin
      pending <= pending_next;
      accum   <= accum_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_consume && res_valid) begin
      out_valid <= 1'b1;
    end else if (units.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_consume && res_valid) begin
      out_item <= res;
    end
  end

  assign units.valid     = out_valid;
  assign units.has_char  = out_item.has_char;
  assign units.unit_low  = out_item.unit_low;
  assign units.unit_high = out_item.unit_high;
  assign units.status    = out_item.status;

  // A fresh result only follows a consumed input item
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    units.valid && !$past(units.valid) |-> $past(s1_valid))
    else $error("result appeared without an input item");

  // A character is delivered exactly when the status is ok
  a_char_iff_ok: assert property (@(posedge clk) disable iff (rst)
    units.valid |-> (units.has_char == (units.status == u8d_pkg::ST_OK)))
    else $error("has_char and status disagree");

  // A high unit only comes with a character
  a_high_needs_char: assert property (@(posedge clk) disable iff (rst)
    units.valid && units.unit_high != 10'd0 |-> units.has_char)
    else $error("high unit set on an error result");

  // End of stream leaves no character open
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    s1_consume && s1_kind == u8d_pkg::KIND_END |=> pending == 2'd0 && accum == '0)
    else $error("state not cleared by end of stream");

endmodule

`default_nettype wire

FILE: tb/utf8_stream_decoder_core_tb.sv
// utf8_stream_decoder_core_tb: self-checking bench for the UTF-8 stream decoder core.
// Drives a directed byte table, then random byte sequences, checks every unit item.
// Depends on u8d_pkg, u8d_byte_if, u8d_unit_if and utf8_stream_decoder_core.
`default_nettype none

module utf8_stream_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving
  localparam int TAIL_CYCLES    = 10;    // drain after the last unit item
  localparam int PHASE_ITEMS    = 438;   // random items per idling phase
  localparam int DIR_ROWS       = 27;

  // One row of the directed table
  typedef struct {
    u8d_pkg::kind_t     kind;
    logic [7:0]         byte_value;
    bit                 typed;      // expected unit typed in below
    u8d_pkg::out_item_t exp;
  } byte_row_t;

  logic clk;
  logic rst;

  u8d_byte_if bytes_ch();
  u8d_unit_if units_ch();

  utf8_stream_decoder_core DUT (
    .clk  (clk),
    .rst  (rst),
    .bytes(bytes_ch),
    .units(units_ch)
  );

  // Decoder state mirror
  u8d_pkg::pend_t bytes_due;
  u8d_pkg::code_t partial_code;

  u8d_pkg::out_item_t expected_units[$];
  byte_row_t dir_rows[0:DIR_ROWS-1];

  int errors;
  int items_sent;
  int idle_cycles;
  int send_idle_pct;
  int stall_pct;

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // Error result: clears decoder state
  function automatic u8d_pkg::out_item_t flag_error(input u8d_pkg::status_t code);
    u8d_pkg::out_item_t res;
    res = '0;
    res.status = code;
    bytes_due = '0;
    partial_code = '0;
    return res;
  endfunction

  // Range check, then basic plane or split offset form
  function automatic u8d_pkg::out_item_t deliver_code(input u8d_pkg::code_t cp);
    u8d_pkg::out_item_t res;
    u8d_pkg::code_t     off;
    if (cp > u8d_pkg::CODE_MAX || (cp >= u8d_pkg::SURR_LO && cp <= u8d_pkg::SURR_HI))
      return flag_error(u8d_pkg::ST_BAD_CODE);
    res = '0;
    res.has_char = 1'b1;
    res.status = u8d_pkg::ST_OK;
    if (cp < u8d_pkg::PLANE1_BASE) begin
      res.unit_low = cp[15:0];
    end else begin
      off = cp - u8d_pkg::PLANE1_BASE;
      res.unit_low = {6'b0, off[9:0]};
      res.unit_high = off[19:10];
    end
    return res;
  endfunction

  // Advance the mirror by one accepted item; returns 1 when a unit item is due
  function automatic bit decode_byte(input u8d_pkg::kind_t k, input logic [7:0] b,
                                     output u8d_pkg::out_item_t res);
    u8d_pkg::code_t cp;
    res = '0;
    if (k == u8d_pkg::KIND_END) begin
      if (bytes_due != 0) begin
        res = flag_error(u8d_pkg::ST_INCOMPLETE);
        return 1'b1;
      end
      partial_code = '0;
      return 1'b0;
    end
    // ASCII
    if (b < u8d_pkg::CONT_MIN) begin
      if (bytes_due != 0) res = flag_error(u8d_pkg::ST_OUT_OF_SEQ);
      else res = deliver_code({13'b0, b});
      return 1'b1;
    end
    if (b >= u8d_pkg::BAD_LEAD_MIN) begin
      res = flag_error(u8d_pkg::ST_BAD_LEAD);
      return 1'b1;
    end
    // Lead bytes
    if (b >= u8d_pkg::LEAD2_MIN) begin
      if (bytes_due != 0) begin
        res = flag_error(u8d_pkg::ST_OUT_OF_SEQ);
        return 1'b1;
      end
      if (b >= u8d_pkg::LEAD4_MIN) begin
        bytes_due = u8d_pkg::PEND_LEAD4;
        partial_code = {18'b0, b[2:0]};
      end else if (b >= u8d_pkg::LEAD3_MIN) begin
        bytes_due = u8d_pkg::PEND_LEAD3;
        partial_code = {17'b0, b[3:0]};
      end else begin
        bytes_due = u8d_pkg::PEND_LEAD2;
        partial_code = {16'b0, b[4:0]};
      end
      return 1'b0;
    end
    // Continuation byte
    if (bytes_due == 0) begin
      res = flag_error(u8d_pkg::ST_OUT_OF_SEQ);
      return 1'b1;
    end
    partial_code = {partial_code[14:0], b[5:0]};
    bytes_due = bytes_due - 2'd1;
    if (bytes_due != 0) return 1'b0;
    cp = partial_code;
    partial_code = '0;
    res = deliver_code(cp);
    return 1'b1;
  endfunction

  // Present one item, wait for acceptance, then queue what it should produce
  task automatic send_byte(input u8d_pkg::kind_t k, input logic [7:0] b,
                           input bit typed = 1'b0,
                           input u8d_pkg::out_item_t typed_exp = '0);
    u8d_pkg::out_item_t res;
    bit                 due;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      bytes_ch.valid <= 1'b0;
      @(negedge clk);
    end
    bytes_ch.valid <= 1'b1;
    bytes_ch.kind <= k;
    bytes_ch.byte_value <= b;
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
    due = decode_byte(k, b, res);
    if (typed) expected_units.push_back(typed_exp);
    else if (due) expected_units.push_back(res);
    items_sent++;
  endtask

  // Sender goes quiet until every queued unit item has come back
  task automatic drain_units();
    @(negedge clk);
    bytes_ch.valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  function automatic logic [7:0] lead_byte(input int len);
    case (len)
      1:       return {1'b0, 7'($urandom_range(127))};
      2:       return {3'b110, 5'($urandom_range(31))};
      3:       return {4'b1110, 4'($urandom_range(15))};
      default: return {5'b11110, 3'($urandom_range(7))};
    endcase
  endfunction

  // Mostly well-formed characters with random payload; the rest ends, cut-off
  // sequences and raw noise bytes
  task automatic send_random_sequence();
    int sel;
    int len;
    int conts;
    sel = $urandom_range(99);
    if (sel < 70) begin
      len = $urandom_range(1, 4);
      send_byte(u8d_pkg::KIND_DATA, lead_byte(len));
      for (int i = 1; i < len; i++) send_byte(u8d_pkg::KIND_DATA, cont_byte());
    end else if (sel < 80) begin
      send_byte(u8d_pkg::KIND_END, 8'($urandom_range(255)));
    end else if (sel < 90) begin
      len = $urandom_range(2, 4);
      conts = $urandom_range(0, len - 2);
      send_byte(u8d_pkg::KIND_DATA, lead_byte(len));
      for (int i = 0; i < conts; i++) send_byte(u8d_pkg::KIND_DATA, cont_byte());
      if ($urandom_range(1)) send_byte(u8d_pkg::KIND_END, 8'($urandom_range(255)));
      else send_byte(u8d_pkg::KIND_DATA, 8'($urandom_range(255)));
    end else begin
      send_byte(u8d_pkg::KIND_DATA, 8'($urandom_range(255)));
    end
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    units_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Unit item checker
  always @(posedge clk) begin
    u8d_pkg::out_item_t exp;
    if (!rst && units_ch.valid && units_ch.ready) begin
      if (expected_units.size() == 0) begin
        report_mismatch($sformatf("unexpected unit item status=%0d has_char=%0b",
                                  units_ch.status, units_ch.has_char));
      end else begin
        exp = expected_units.pop_front();
        if (units_ch.has_char !== exp.has_char)
          report_mismatch($sformatf("has_char got %0b exp %0b",
                                    units_ch.has_char, exp.has_char));
        if (units_ch.unit_low !== exp.unit_low)
          report_mismatch($sformatf("unit_low got %h exp %h",
                                    units_ch.unit_low, exp.unit_low));
        if (units_ch.unit_high !== exp.unit_high)
          report_mismatch($sformatf("unit_high got %h exp %h",
                                    units_ch.unit_high, exp.unit_high));
        if (units_ch.status !== exp.status)
          report_mismatch($sformatf("status got %0d exp %0d",
                                    units_ch.status, exp.status));
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (bytes_ch.valid && bytes_ch.ready) || (units_ch.valid && units_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT @%0t: no item moved for %0d cycles, %0d unit items outstanding",
               $time, WATCHDOG_LIMIT, expected_units.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int send_pct_by_phase[4];
    int stall_pct_by_phase[4];
    int phase_end;
    send_pct_by_phase  = '{0, 82, 0, 18};
    stall_pct_by_phase = '{0, 0, 82, 18};

    // Directed table: extremes, each byte class and each error case
    dir_rows = '{
      '{u8d_pkg::KIND_DATA, 8'h00, 1'b1, '{1'b1, 16'h0000, 10'h000, u8d_pkg::ST_OK}},
      '{u8d_pkg::KIND_DATA, 8'hFF, 1'b1, '{1'b0, 16'h0000, 10'h000, u8d_pkg::ST_BAD_LEAD}},
      '{u8d_pkg::KIND_DATA, 8'hF8, 1'b1, '{1'b0, 16'h0000, 10'h000, u8d_pkg::ST_BAD_LEAD}},
      '{u8d_pkg::KIND_DATA, 8'h80, 1'b1, '{1'b0, 16'h0000, 10'h000, u8d_pkg::ST_OUT_OF_SEQ}},
      '{u8d_pkg::KIND_DATA, 8'hC3, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'hA9, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'hE2, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'h82, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'hAC, 1'b0, '0},
      // largest legal code point
      '{u8d_pkg::KIND_DATA, 8'hF4, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'h8F, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'hBF, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'hBF, 1'b1, '{1'b1, 16'h03FF, 10'h3FF, u8d_pkg::ST_OK}},
      // surrogate
      '{u8d_pkg::KIND_DATA, 8'hED, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'hA0, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'h80, 1'b1, '{1'b0, 16'h0000, 10'h000, u8d_pkg::ST_BAD_CODE}},
      // beyond the code space
      '{u8d_pkg::KIND_DATA, 8'hF7, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'hBF, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'hBF, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'hBF, 1'b1, '{1'b0, 16'h0000, 10'h000, u8d_pkg::ST_BAD_CODE}},
      // ASCII while pending
      '{u8d_pkg::KIND_DATA, 8'hC2, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'h7F, 1'b1, '{1'b0, 16'h0000, 10'h000, u8d_pkg::ST_OUT_OF_SEQ}},
      // lead while pending
      '{u8d_pkg::KIND_DATA, 8'hE0, 1'b0, '0},
      '{u8d_pkg::KIND_DATA, 8'hF7, 1'b1, '{1'b0, 16'h0000, 10'h000, u8d_pkg::ST_OUT_OF_SEQ}},
      // incomplete at end, then a clean end
      '{u8d_pkg::KIND_DATA, 8'hF0, 1'b0, '0},
      '{u8d_pkg::KIND_END,  8'h00, 1'b1, '{1'b0, 16'h0000, 10'h000, u8d_pkg::ST_INCOMPLETE}},
      '{u8d_pkg::KIND_END,  8'hFF, 1'b0, '0}
    };

    clk = 1'b0;
    rst = 1'b1;
    bytes_ch.valid = 1'b0;
    bytes_ch.kind = u8d_pkg::KIND_DATA;
    bytes_ch.byte_value = 8'h00;
    units_ch.ready = 1'b0;
    bytes_due = '0;
    partial_code = '0;
    errors = 0;
    items_sent = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(dir_rows[i].kind, dir_rows[i].byte_value, dir_rows[i].typed, dir_rows[i].exp);

    // Random part, one idling phase at a time; sender drains between phases
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct_by_phase[p];
      stall_pct = stall_pct_by_phase[p];
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_random_sequence();
      drain_units();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
